>>> design/mask_iou_best_match_unit_defines.svh
// Assertion macros shared by the mask IoU best match unit.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MASK_IOU_BEST_MATCH_UNIT_DEFINES_SVH
`define MASK_IOU_BEST_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MIOU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MIOU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/miou_pkg.sv
// Package for the mask IoU best match unit: field widths and the queue entry type.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package miou_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W     = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PROD_W     = 2 * CNT_W;

  localparam logic [PIX_W-1:0] FG_RESET = 8'd255;

  // One classified pixel pair as it travels from the front to the back end.
  typedef struct packed {
    logic c_on;
    logic q_on;
    logic eoi;
    logic eos;
  } miou_item_t;

endpackage

>>> design/miou_front.sv
// Front end: holds the foreground level register and classifies each pixel pair.
// Depends on miou_pkg.
`timescale 1ns / 1ps

module miou_front
  import miou_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [PIX_W-1:0] cfg_wdata,
  input  logic [PIX_W-1:0] cand_pix,
  input  logic [PIX_W-1:0] query_pix,
  input  logic             eoi,
  input  logic             eos,
  output miou_item_t       item
);

  logic [PIX_W-1:0] fg_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_level_r <= FG_RESET;
    end else if (cfg_we) begin
      fg_level_r <= cfg_wdata;
    end
  end

  // end_of_set only counts together with end_of_image.
  always_comb begin
    item.c_on = (cand_pix == fg_level_r);
    item.q_on = (query_pix == fg_level_r);
    item.eoi  = eoi;
    item.eos  = eos & eoi;
  end

endmodule

>>> design/miou_fifo.sv
// Short first-in first-out queue of classified pixel pairs between front and back end.
// Depends on miou_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "mask_iou_best_match_unit_defines.svh"

module miou_fifo
  import miou_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  miou_item_t wr_item,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output miou_item_t rd_item
);

  miou_item_t        mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  assign full      = (fill_r == FILL_W'(FIFO_DEPTH));
  assign not_empty = (fill_r != '0);
  assign rd_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - FILL_W'(1);
      end
    end
  end

  `MIOU_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(FIFO_DEPTH), "fifo over depth")
  `MIOU_ASSERT_NOW(a_pop_not_empty, clk, rst_n, pop, fill_r != '0, "pop from empty fifo")
  `MIOU_ASSERT_NEXT(a_fill_grows, clk, rst_n, push && !pop, fill_r == $past(fill_r) + FILL_W'(1), "fill count lost a push")

endmodule

>>> design/miou_back.sv
// Back end: counts intersection and union per candidate, then scores each candidate
// against the best so far by cross multiplication. Depends on miou_pkg and the macros header.
`timescale 1ns / 1ps
`include "mask_iou_best_match_unit_defines.svh"

module miou_back
  import miou_pkg::*;
#(
  parameter int unsigned MAX_PIXELS     = 1048576,
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_avail,
  input  miou_item_t       item,
  output logic             item_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [IDX_W-1:0] res_index,
  output logic [CNT_W-1:0] res_inter,
  output logic [CNT_W-1:0] res_union
);

  localparam int unsigned CNT_MAX  = (1 << CNT_W) - 1;
  localparam int unsigned IDX_LIM  = (MAX_CANDIDATES > (1 << IDX_W)) ? (1 << IDX_W)
                                                                      : MAX_CANDIDATES;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'((MAX_PIXELS > CNT_MAX) ? CNT_MAX
                                                                        : MAX_PIXELS);
  localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(IDX_LIM - 1);

  logic             back_en;

  // Counting stage
  logic [CNT_W-1:0] inter_r, union_r;
  logic [CNT_W-1:0] inter_nxt, union_nxt;
  logic [IDX_W-1:0] cand_r;

  // Scoring stage
  logic             s2_valid_r;
  logic             s2_eos_r;
  logic [CNT_W-1:0] s2_inter_r, s2_union_r;
  logic [IDX_W-1:0] s2_slot_r;

  logic [CNT_W-1:0] best_inter_r, best_uni_r;
  logic [IDX_W-1:0] best_slot_r;
  logic             have_best_r;

  logic [CNT_W-1:0] num_a, den_a, num_b, den_b;
  logic [PROD_W-1:0] prod_a, prod_b;
  logic             wins;
  logic [CNT_W-1:0] win_inter, win_union;
  logic [IDX_W-1:0] win_slot;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_index_r;
  logic [CNT_W-1:0] out_inter_r, out_union_r;

  // The whole back end advances unless a finished result is still waiting.
  assign back_en  = !out_valid_r || res_ready;
  assign item_pop = item_avail && back_en;

  always_comb begin
    inter_nxt = inter_r;
    union_nxt = union_r;
    if (item.c_on && item.q_on && (inter_r < CNT_CAP)) begin
      inter_nxt = inter_r + CNT_W'(1);
    end
    if ((item.c_on || item.q_on) && (union_r < CNT_CAP)) begin
      union_nxt = union_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inter_r <= '0;
      union_r <= '0;
      cand_r  <= '0;
    end else if (item_pop) begin
      if (item.eoi) begin
        inter_r <= '0;
        union_r <= '0;
        if (item.eos) begin
          cand_r <= '0;
        end else if (cand_r < IDX_CAP) begin
          cand_r <= cand_r + IDX_W'(1);
        end
      end else begin
        inter_r <= inter_nxt;
        union_r <= union_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (back_en) begin
      s2_valid_r <= item_pop && item.eoi;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && item.eoi) begin
      s2_inter_r <= inter_nxt;
      s2_union_r <= union_nxt;
      s2_slot_r  <= cand_r;
      s2_eos_r   <= item.eos;
    end
  end

  // An empty union scores 0, written as 0/1.
  always_comb begin
    num_a  = (s2_union_r == '0) ? '0 : s2_inter_r;
    den_a  = (s2_union_r == '0) ? CNT_W'(1) : s2_union_r;
    num_b  = (best_uni_r == '0) ? '0 : best_inter_r;
    den_b  = (best_uni_r == '0) ? CNT_W'(1) : best_uni_r;
    prod_a = PROD_W'(num_a) * PROD_W'(den_b);
    prod_b = PROD_W'(num_b) * PROD_W'(den_a);
    wins   = !have_best_r || (prod_a > prod_b);
    win_inter = wins ? s2_inter_r : best_inter_r;
    win_union = wins ? s2_union_r : best_uni_r;
    win_slot  = wins ? s2_slot_r  : best_slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_inter_r <= '0;
      best_uni_r   <= '0;
      best_slot_r  <= '0;
      have_best_r  <= 1'b0;
    end else if (s2_valid_r && back_en) begin
      if (s2_eos_r) begin
        best_inter_r <= '0;
        best_uni_r   <= '0;
        best_slot_r  <= '0;
        have_best_r  <= 1'b0;
      end else begin
        best_inter_r <= win_inter;
        best_uni_r   <= win_union;
        best_slot_r  <= win_slot;
        have_best_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_valid_r && s2_eos_r && back_en) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && s2_eos_r && back_en) begin
      out_index_r <= win_slot;
      out_inter_r <= win_inter;
      out_union_r <= win_union;
    end
  end

  assign res_valid = out_valid_r;
  assign res_index = out_index_r;
  assign res_inter = out_inter_r;
  assign res_union = out_union_r;

  `MIOU_ASSERT_NOW(a_inter_le_union, clk, rst_n, 1'b1, inter_r <= union_r, "inter above union")
  `MIOU_ASSERT_NOW(a_best_le_union, clk, rst_n, 1'b1, best_inter_r <= best_uni_r, "best over")
  `MIOU_ASSERT_NEXT(a_set_end, clk, rst_n, s2_valid_r && s2_eos_r && back_en, out_valid_r && !have_best_r, "set end lost")

endmodule

>>> design/mask_iou_best_match_unit.sv
// Mask IoU best match unit, top level: joins front end, queue and back end.
// Depends on miou_pkg, miou_front, miou_fifo and miou_back.
//
// Input channel: each request is one pixel pair, the candidate pixel and the query pixel at
// the same position. in_tlast marks the last pixel of a candidate image and in_tuser, with
// in_tlast, marks the last candidate of the set. Output channel: one request per set, the
// index of the candidate with the best intersection over union and its two counts.
// Configuration: cfg_we writes the foreground level; write it only while the block is idle.
// Throughput is one pixel pair per clock while in_tready is high. The front end classifies a
// pair in the cycle it is accepted and writes it into a four-entry queue; the back end takes
// it from the queue and counts it, then scores a finished candidate from the scoring register
// with two 21 by 21 bit products; the set's result is held in the register behind out_tvalid.
// Reset (synchronous, rst_n low) clears all counts, the best candidate and the queue, and
// sets the foreground level to 255. When the receiver stalls, the result is held in the
// output register and the back end pauses; the queue still absorbs up to four requests
// before in_tready falls.
`timescale 1ns / 1ps

module mask_iou_best_match_unit
  import miou_pkg::*;
#(
  parameter int unsigned MAX_PIXELS     = 1048576,
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,      // foreground_level
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,       // [7:0] candidate_pixel, [15:8] query_pixel
  input  logic        in_tlast,       // end_of_image
  input  logic        in_tuser,       // end_of_set
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata       // [7:0] winning candidate number,
                                      // [28:8] best_intersection,
                                      // [49:29] best_union, [55:50] zero
);

  miou_item_t       front_item;
  miou_item_t       queue_item;
  logic             queue_full;
  logic             queue_avail;
  logic             queue_pop;
  logic             in_push;
  logic [IDX_W-1:0] res_index;
  logic [CNT_W-1:0] res_inter;
  logic [CNT_W-1:0] res_union;

  assign in_tready = !queue_full;
  assign in_push   = in_tvalid && !queue_full;

  miou_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cand_pix  (in_tdata[7:0]),
    .query_pix (in_tdata[15:8]),
    .eoi       (in_tlast),
    .eos       (in_tuser),
    .item      (front_item)
  );

  miou_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .wr_item   (front_item),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_avail),
    .rd_item   (queue_item)
  );

  miou_back #(
    .MAX_PIXELS     (MAX_PIXELS),
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_avail (queue_avail),
    .item       (queue_item),
    .item_pop   (queue_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_index  (res_index),
    .res_inter  (res_inter),
    .res_union  (res_union)
  );

  // Fields packed from the lowest bit up, padded with zeros to whole bytes.
  assign out_tdata = {6'd0, res_union, res_inter, res_index};

endmodule
